// File: src/bmap_pkg.sv
package bmap_pkg;

	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = 64;
	localparam int TOTAL_BITS = WORD_BITS * NUM_WORDS;

	localparam int BIT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int WI_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int ACT_W   = 3;
	localparam int START_W = 11;
	localparam int COUNT_W = 12;
	localparam int SPAN_W  = 7;
	localparam int SUM_W   = COUNT_W + 1;

	localparam logic [ACT_W-1:0] ACT_SET_BIT   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLR_BIT   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET_RANGE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLR_RANGE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FIND      = 3'd4;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WI_W-1:0]      widx_t;
	typedef logic [BIT_W-1:0]     bpos_t;

	// Run geometry handed to the word unit.
	typedef struct packed {
		widx_t w_first;
		widx_t w_last;
		bpos_t lo;
		bpos_t hi;
		logic  set;
	} run_ctl_t;

endpackage

// File: src/bmap_if.sv
interface bmap_req_if;
	logic                              valid;
	logic                              ready;
	logic [bmap_pkg::ACT_W-1:0]        action;
	logic [bmap_pkg::START_W-1:0]      start_index;
	logic [bmap_pkg::COUNT_W-1:0]      bit_count;
	logic [bmap_pkg::SPAN_W-1:0]       span_words;

	modport source(output valid, action, start_index, bit_count, span_words, input ready);
	modport sink(input valid, action, start_index, bit_count, span_words, output ready);
endinterface

interface bmap_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [bmap_pkg::START_W-1:0]      first_index;
	logic                              range_error;

	modport source(output valid, found, first_index, range_error, input ready);
	modport sink(input valid, found, first_index, range_error, output ready);
endinterface

// File: src/bmap_store.sv
module bmap_store (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  bmap_pkg::widx_t  rd_addr,
	output bmap_pkg::word_t  rd_data,
	input  logic             wr_en,
	input  bmap_pkg::widx_t  wr_addr,
	input  bmap_pkg::word_t  wr_data
);

	bmap_pkg::word_t                 mem [bmap_pkg::NUM_WORDS];
	logic [bmap_pkg::NUM_WORDS-1:0]  vld_q;
	bmap_pkg::word_t                 data_s1;
	logic                            vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
		end
	end

	// A word never written since reset reads as all zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

// File: src/bmap_word_unit.sv
module bmap_word_unit (
	input  bmap_pkg::word_t   word,
	input  bmap_pkg::widx_t   addr,
	input  bmap_pkg::run_ctl_t ctl,
	output bmap_pkg::word_t   new_word,
	output logic              nonzero,
	output bmap_pkg::bpos_t   low_pos
);

	localparam bmap_pkg::word_t FULL = '1;

	bmap_pkg::bpos_t lo_e;
	bmap_pkg::bpos_t hi_e;
	bmap_pkg::bpos_t shamt;
	bmap_pkg::word_t mask;
	bmap_pkg::word_t iso;

	always_comb begin
		lo_e  = (addr == ctl.w_first) ? ctl.lo : '0;
		hi_e  = (addr == ctl.w_last) ? ctl.hi : bmap_pkg::BIT_W'(bmap_pkg::WORD_BITS - 1);
		shamt = bmap_pkg::BIT_W'(bmap_pkg::WORD_BITS - 1) - (hi_e - lo_e);
		mask  = (FULL >> shamt) << lo_e;
		new_word = ctl.set ? (word | mask) : (word & ~mask);
	end

	// Isolate the lowest set bit, then encode its position.
	always_comb begin
		iso     = word & (~word + bmap_pkg::WORD_BITS'(1));
		nonzero = |word;
		low_pos = '0;
		for (int i = 0; i < bmap_pkg::WORD_BITS; i++) begin
			if (iso[i]) begin
				low_pos = low_pos | bmap_pkg::BIT_W'(i);
			end
		end
	end

endmodule

// File: src/bitmap_range_set_clear_find.sv
// A rejected, empty or undefined request goes straight from accept to the result; otherwise
// the block examines each word of the run in turn, up to NUM_WORDS words.
// One request at a time; a new request is taken in the cycle after the result is loaded.
// The store's read port and write port each handle one word per cycle, pipelined so a word is read
// while the previous one is written back. A stalled result holds the block busy.
// Reset: arst_n clears the bitmap at once through per-word valid bits; ready is high out of reset.
module bitmap_range_set_clear_find (
	input  logic       clk,
	input  logic       arst_n,
	bmap_req_if.sink   req,
	bmap_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	localparam logic [bmap_pkg::SUM_W-1:0]  TOTAL_SUM  = bmap_pkg::SUM_W'(bmap_pkg::TOTAL_BITS);
	localparam logic [bmap_pkg::SPAN_W-1:0] SPAN_LIMIT = bmap_pkg::SPAN_W'(bmap_pkg::NUM_WORDS);

	state_t              state_q;
	logic                scan_q;
	logic                iss_q;
	bmap_pkg::widx_t     w_q;
	bmap_pkg::run_ctl_t  ctl_q;
	logic                pend_s1;
	bmap_pkg::widx_t     addr_s1;

	logic                        res_found_q;
	logic [bmap_pkg::START_W-1:0] res_idx_q;
	logic                        res_err_q;

	logic                        out_vld_q;
	logic                        out_found_q;
	logic [bmap_pkg::START_W-1:0] out_idx_q;
	logic                        out_err_q;

	logic                         acc;
	logic                         out_free;
	logic [bmap_pkg::SUM_W-1:0]   run_end;
	logic [bmap_pkg::START_W-1:0] run_last;
	bmap_pkg::word_t              rd_data;
	bmap_pkg::word_t              new_word;
	logic                         nonzero;
	bmap_pkg::bpos_t              low_pos;
	logic                         proc;
	logic                         rd_en;
	logic                         wr_en;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign run_end   = bmap_pkg::SUM_W'(req.start_index) + bmap_pkg::SUM_W'(req.bit_count);
	assign run_last  = bmap_pkg::START_W'(run_end - bmap_pkg::SUM_W'(1));
	assign proc      = (state_q == ST_RUN) && pend_s1;
	assign rd_en     = (state_q == ST_RUN) && iss_q;
	assign wr_en     = proc && !scan_q;

	bmap_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (w_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (new_word)
	);

	bmap_word_unit u_word (
		.word     (rd_data),
		.addr     (addr_s1),
		.ctl      (ctl_q),
		.new_word (new_word),
		.nonzero  (nonzero),
		.low_pos  (low_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= 1'b0;
			iss_q       <= 1'b0;
			pend_s1     <= 1'b0;
			res_found_q <= 1'b0;
			res_err_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						res_found_q <= 1'b0;
						res_idx_q   <= '0;
						res_err_q   <= 1'b0;
						scan_q      <= 1'b0;
						iss_q       <= 1'b0;
						pend_s1     <= 1'b0;
						state_q     <= ST_DONE;
						if (req.action == bmap_pkg::ACT_SET_BIT ||
						    req.action == bmap_pkg::ACT_CLR_BIT) begin
							if (bmap_pkg::SUM_W'(req.start_index) >= TOTAL_SUM) begin
								res_err_q <= 1'b1;
							end else begin
								w_q            <= bmap_pkg::WI_W'(req.start_index >> bmap_pkg::BIT_W);
								ctl_q.w_first  <= bmap_pkg::WI_W'(req.start_index >> bmap_pkg::BIT_W);
								ctl_q.w_last   <= bmap_pkg::WI_W'(req.start_index >> bmap_pkg::BIT_W);
								ctl_q.lo       <= bmap_pkg::BIT_W'(req.start_index);
								ctl_q.hi       <= bmap_pkg::BIT_W'(req.start_index);
								ctl_q.set      <= (req.action == bmap_pkg::ACT_SET_BIT);
								iss_q          <= 1'b1;
								state_q        <= ST_RUN;
							end
						end else if (req.action == bmap_pkg::ACT_SET_RANGE ||
						             req.action == bmap_pkg::ACT_CLR_RANGE) begin
							if (req.bit_count == '0) begin
								// Empty run: nothing to do.
							end else if (run_end > TOTAL_SUM) begin
								res_err_q <= 1'b1;
							end else begin
								w_q            <= bmap_pkg::WI_W'(req.start_index >> bmap_pkg::BIT_W);
								ctl_q.w_first  <= bmap_pkg::WI_W'(req.start_index >> bmap_pkg::BIT_W);
								ctl_q.w_last   <= bmap_pkg::WI_W'(run_last >> bmap_pkg::BIT_W);
								ctl_q.lo       <= bmap_pkg::BIT_W'(req.start_index);
								ctl_q.hi       <= bmap_pkg::BIT_W'(run_last);
								ctl_q.set      <= (req.action == bmap_pkg::ACT_SET_RANGE);
								iss_q          <= 1'b1;
								state_q        <= ST_RUN;
							end
						end else if (req.action == bmap_pkg::ACT_FIND) begin
							if (req.span_words > SPAN_LIMIT) begin
								res_err_q <= 1'b1;
							end else if (req.span_words != '0) begin
								w_q            <= '0;
								ctl_q.w_first  <= '0;
								ctl_q.w_last   <= bmap_pkg::WI_W'(req.span_words - bmap_pkg::SPAN_W'(1));
								ctl_q.lo       <= '0;
								ctl_q.hi       <= '0;
								ctl_q.set      <= 1'b0;
								scan_q         <= 1'b1;
								iss_q          <= 1'b1;
								state_q        <= ST_RUN;
							end
						end
					end
				end
				ST_RUN: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						addr_s1 <= w_q;
						if (w_q == ctl_q.w_last) begin
							iss_q <= 1'b0;
						end else begin
							w_q <= w_q + bmap_pkg::WI_W'(1);
						end
					end
					if (proc) begin
						if (scan_q && nonzero) begin
							res_found_q <= 1'b1;
							res_idx_q   <= bmap_pkg::START_W'({addr_s1, low_pos});
							iss_q       <= 1'b0;
							pend_s1     <= 1'b0;
							state_q     <= ST_DONE;
						end else if (addr_s1 == ctl_q.w_last) begin
							iss_q   <= 1'b0;
							pend_s1 <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (state_q == ST_DONE && out_free) begin
				out_vld_q   <= 1'b1;
				out_found_q <= res_found_q;
				out_idx_q   <= res_idx_q;
				out_err_q   <= res_err_q;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.found       = out_found_q;
	assign rsp.first_index = out_idx_q;
	assign rsp.range_error = out_err_q;

endmodule

// File: src/bmap_chk.sv
module bmap_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic                               rsp_found,
	input logic [bmap_pkg::START_W-1:0]       rsp_first_index,
	input logic                               rsp_range_error
);

	// A stalled result beat keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
		$stable(rsp_first_index) && $stable(rsp_range_error))
		else $error("result beat changed while stalled");

	// A request is still in progress in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready in the cycle after an accepted request");

	// A rejected request never reports a hit.
	a_err_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_found && rsp_range_error))
		else $error("hit reported together with a range error");

	// Without a hit the reported index is zero.
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_first_index == '0)
		else $error("nonzero index without a hit");

endmodule

bind bitmap_range_set_clear_find bmap_chk u_bmap_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_first_index (rsp.first_index),
	.rsp_range_error (rsp.range_error)
);

// File: dv/tb_bitmap_range_set_clear_find.sv
`timescale 1ns / 100ps

module tb_bitmap_range_set_clear_find;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 125;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [bmap_pkg::ACT_W-1:0]   action;
		logic [bmap_pkg::START_W-1:0] start_index;
		logic [bmap_pkg::COUNT_W-1:0] bit_count;
		logic [bmap_pkg::SPAN_W-1:0]  span_words;
	} bmap_req_t;

	typedef struct packed {
		logic                         found;
		logic [bmap_pkg::START_W-1:0] first_index;
		logic                         range_error;
	} bmap_rsp_t;

	logic clk;
	logic arst_n;
	logic req_fire;

	bmap_req_if req_bus ();
	bmap_rsp_if rsp_bus ();

	bitmap_range_set_clear_find DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	bmap_pkg::word_t bitmap_mirror [bmap_pkg::NUM_WORDS];
	bmap_req_t       request_queue [$];
	bmap_rsp_t       predicted_results [$];
	int              send_idle_pct;
	int              recv_stall_pct;
	int              mismatch_count;
	int              cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one request to the mirror and returns the result it should produce.
	function automatic bmap_rsp_t apply_request(bmap_req_t r);
		bmap_rsp_t       res;
		int unsigned     first, last, w0, w1, lo, hi, w, b;
		bmap_pkg::word_t full, m;
		res = '0;
		full = '1;
		case (r.action)
			bmap_pkg::ACT_SET_BIT, bmap_pkg::ACT_CLR_BIT: begin
				if (r.start_index >= bmap_pkg::TOTAL_BITS) begin
					res.range_error = 1'b1;
				end else begin
					w = r.start_index / bmap_pkg::WORD_BITS;
					b = r.start_index % bmap_pkg::WORD_BITS;
					bitmap_mirror[w][b] = (r.action == bmap_pkg::ACT_SET_BIT);
				end
			end
			bmap_pkg::ACT_SET_RANGE, bmap_pkg::ACT_CLR_RANGE: begin
				if (r.bit_count != 0) begin
					first = r.start_index;
					if (first + r.bit_count > bmap_pkg::TOTAL_BITS) begin
						res.range_error = 1'b1;
					end else begin
						last = first + r.bit_count - 1;
						w0 = first / bmap_pkg::WORD_BITS;
						w1 = last / bmap_pkg::WORD_BITS;
						for (w = w0; w <= w1; w++) begin
							lo = (w == w0) ? first % bmap_pkg::WORD_BITS : 0;
							hi = (w == w1) ? last % bmap_pkg::WORD_BITS : bmap_pkg::WORD_BITS - 1;
							m = (full >> (bmap_pkg::WORD_BITS - 1 - (hi - lo))) << lo;
							if (r.action == bmap_pkg::ACT_SET_RANGE)
								bitmap_mirror[w] |= m;
							else
								bitmap_mirror[w] &= ~m;
						end
					end
				end
			end
			bmap_pkg::ACT_FIND: begin
				if (r.span_words > bmap_pkg::NUM_WORDS) begin
					res.range_error = 1'b1;
				end else begin
					for (w = 0; w < r.span_words && !res.found; w++) begin
						if (bitmap_mirror[w] != '0) begin
							b = 0;
							while (!bitmap_mirror[w][b])
								b++;
							res.found = 1'b1;
							res.first_index = bmap_pkg::START_W'(w * bmap_pkg::WORD_BITS + b);
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic queue_request(logic [bmap_pkg::ACT_W-1:0] action, int unsigned start_index,
			int unsigned bit_count, int unsigned span_words);
		bmap_req_t r;
		r.action = action;
		r.start_index = bmap_pkg::START_W'(start_index);
		r.bit_count = bmap_pkg::COUNT_W'(bit_count);
		r.span_words = bmap_pkg::SPAN_W'(span_words);
		request_queue.push_back(r);
	endtask

	// Runs are biased toward word edges, the end of the store and lengths that just fit.
	task automatic queue_random_request();
		int unsigned sel, start_index, bit_count, span_words;
		logic [bmap_pkg::ACT_W-1:0] action;
		sel = $urandom_range(0, 99);
		if (sel < 20)
			action = bmap_pkg::ACT_SET_BIT;
		else if (sel < 33)
			action = bmap_pkg::ACT_CLR_BIT;
		else if (sel < 55)
			action = bmap_pkg::ACT_SET_RANGE;
		else if (sel < 68)
			action = bmap_pkg::ACT_CLR_RANGE;
		else if (sel < 97)
			action = bmap_pkg::ACT_FIND;
		else
			action = bmap_pkg::ACT_W'($urandom_range(int'(bmap_pkg::ACT_FIND) + 1,
				(1 << bmap_pkg::ACT_W) - 1));
		case ($urandom_range(0, 3))
			0: start_index = $urandom_range(0, bmap_pkg::TOTAL_BITS - 1);
			1: start_index = $urandom_range(bmap_pkg::TOTAL_BITS - 48, bmap_pkg::TOTAL_BITS - 1);
			2: start_index = $urandom_range(0, bmap_pkg::NUM_WORDS - 1) * bmap_pkg::WORD_BITS +
					($urandom_range(0, 1) ? bmap_pkg::WORD_BITS - 1 : 0);
			default: start_index = $urandom_range(0, 4 * bmap_pkg::WORD_BITS - 1);
		endcase
		case ($urandom_range(0, 9))
			0: bit_count = 0;
			1, 2, 3, 4, 5: bit_count = $urandom_range(1, 40);
			6, 7: bit_count = $urandom_range(1, 300);
			8: bit_count = bmap_pkg::TOTAL_BITS - start_index + $urandom_range(0, 2) - 1;
			default: bit_count = $urandom_range(0, (1 << bmap_pkg::COUNT_W) - 1);
		endcase
		case ($urandom_range(0, 9))
			0: span_words = bmap_pkg::NUM_WORDS;
			1: span_words = $urandom_range(bmap_pkg::NUM_WORDS + 1, (1 << bmap_pkg::SPAN_W) - 1);
			default: span_words = $urandom_range(0, bmap_pkg::NUM_WORDS);
		endcase
		queue_request(action, start_index, bit_count, span_words);
	endtask

	task automatic drain();
		while (request_queue.size() != 0 || req_bus.valid || predicted_results.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		bmap_req_t nxt;
		bit        send;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			rsp_bus.ready <= 1'b0;
		end else begin
			if (!req_bus.valid || req_fire) begin
				send = request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
				if (send) begin
					nxt = request_queue.pop_front();
					req_bus.action <= nxt.action;
					req_bus.start_index <= nxt.start_index;
					req_bus.bit_count <= nxt.bit_count;
					req_bus.span_words <= nxt.span_words;
				end
				req_bus.valid <= send;
			end
			rsp_bus.ready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		bmap_req_t r;
		bmap_rsp_t got, want;
		req_fire <= arst_n && req_bus.valid && req_bus.ready;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.found = rsp_bus.found;
				got.first_index = rsp_bus.first_index;
				got.range_error = rsp_bus.range_error;
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result beat: found=%0d first_index=%0d range_error=%0d",
							got.found, got.first_index, got.range_error);
				end else begin
					want = predicted_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("mismatch: expected found=%0d first_index=%0d range_error=%0d,",
								want.found, want.first_index, want.range_error,
								" got found=%0d first_index=%0d range_error=%0d",
								got.found, got.first_index, got.range_error);
					end
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				r.action = req_bus.action;
				r.start_index = req_bus.start_index;
				r.bit_count = req_bus.bit_count;
				r.span_words = req_bus.span_words;
				predicted_results.push_back(apply_request(r));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_fire = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.action = bmap_pkg::ACT_SET_BIT;
		req_bus.start_index = '0;
		req_bus.bit_count = '0;
		req_bus.span_words = '0;
		rsp_bus.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		cycle_count = 0;
		foreach (bitmap_mirror[i])
			bitmap_mirror[i] = '0;

		// Directed part: store edges, word-crossing runs, empty, oversized and undefined requests.
		queue_request(bmap_pkg::ACT_FIND, 0, 0, bmap_pkg::NUM_WORDS);
		queue_request(bmap_pkg::ACT_SET_BIT, 0, 0, 0);
		queue_request(bmap_pkg::ACT_SET_BIT, bmap_pkg::TOTAL_BITS - 1, 0, 0);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, bmap_pkg::NUM_WORDS);
		queue_request(bmap_pkg::ACT_CLR_BIT, 0, 0, 0);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, 1);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, bmap_pkg::NUM_WORDS);
		queue_request(bmap_pkg::ACT_CLR_BIT, bmap_pkg::TOTAL_BITS - 1, 0, 0);
		queue_request(bmap_pkg::ACT_SET_RANGE, 0, 0, 0);
		queue_request(bmap_pkg::ACT_SET_RANGE, bmap_pkg::WORD_BITS - 2, 5, 0);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, bmap_pkg::NUM_WORDS);
		queue_request(bmap_pkg::ACT_CLR_RANGE, bmap_pkg::WORD_BITS - 1, 3, 0);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, bmap_pkg::NUM_WORDS);
		queue_request(bmap_pkg::ACT_SET_RANGE, bmap_pkg::WORD_BITS, bmap_pkg::WORD_BITS, 0);
		queue_request(bmap_pkg::ACT_SET_RANGE, 0, bmap_pkg::TOTAL_BITS, 0);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, 0);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, bmap_pkg::NUM_WORDS + 1);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, (1 << bmap_pkg::SPAN_W) - 1);
		queue_request(bmap_pkg::ACT_CLR_RANGE, 1, bmap_pkg::TOTAL_BITS - 1, 0);
		queue_request(bmap_pkg::ACT_FIND, 0, 0, bmap_pkg::NUM_WORDS);
		queue_request(bmap_pkg::ACT_SET_RANGE, bmap_pkg::TOTAL_BITS - 1, 2, 0);
		queue_request(bmap_pkg::ACT_CLR_RANGE, bmap_pkg::TOTAL_BITS / 2,
			(1 << bmap_pkg::COUNT_W) - 1, 0);
		queue_request(bmap_pkg::ACT_CLR_RANGE, 0, bmap_pkg::TOTAL_BITS, 0);
		queue_request(bmap_pkg::ACT_W'(bmap_pkg::ACT_FIND + 1), bmap_pkg::TOTAL_BITS - 1,
			(1 << bmap_pkg::COUNT_W) - 1, (1 << bmap_pkg::SPAN_W) - 1);
		queue_request(bmap_pkg::ACT_W'(bmap_pkg::ACT_FIND + 3), 5, 7, 3);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			repeat (RANDOM_ITEMS)
				queue_random_request();
			drain();
		end

		repeat (bmap_pkg::NUM_WORDS + 8) @(posedge clk);
		if (predicted_results.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
